// ===== src/cpcbw_pkg.sv =====
// Shared types, constants and helper functions of the prefix-code bit writer.
package cpcbw_pkg;

  localparam int NumCodes      = 4;
  localparam int MaxSymbols    = 704;
  localparam int MaxCodeLength = 15;
  localparam int MaxRawBits    = 32;

  localparam int TableDepth = NumCodes * MaxSymbols;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int IdW        = 2;
  localparam int SymW       = 10;
  localparam int LenW       = 4;
  localparam int CodeW      = 15;
  localparam int CntW       = 6;
  localparam int AccW       = 7 + MaxRawBits;
  localparam int RawMaskW   = MaxRawBits + 1;

  localparam logic [2:0] CmdDefine  = 3'd0;
  localparam logic [2:0] CmdEncode  = 3'd1;
  localparam logic [2:0] CmdRaw     = 3'd2;
  localparam logic [2:0] CmdAlign   = 3'd3;
  localparam logic [2:0] CmdLiteral = 3'd4;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StClear = 5'b00010,
    StDefw  = 5'b00100,
    StRead  = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  typedef struct packed {
    logic            valid;
    logic [LenW-1:0] len;
    logic [CodeW-1:0] code;
  } tbl_word_t;

  // flat table address: table base plus symbol
  function automatic logic [AddrW-1:0] tbl_addr(logic [IdW-1:0] id, logic [SymW-1:0] sym);
    return AddrW'(32'(id) * MaxSymbols + 32'(sym));
  endfunction

  // reversed increment over the low len bits: clear ones from the top down
  // until a zero is found, then set it
  function automatic logic [CodeW-1:0] rev_advance(logic [CodeW-1:0] c, logic [LenW-1:0] len);
    logic [CodeW-1:0] r;
    logic             carry;
    r     = c;
    carry = 1'b1;
    for (int i = CodeW - 1; i >= 0; i--) begin
      if (i < int'(len)) begin
        r[i]  = c[i] ^ carry;
        carry = carry & c[i];
      end
    end
    return r;
  endfunction

endpackage

// ===== src/canonical_prefix_code_bit_writer_top.sv =====
// Prefix-code table store and LSB-first bit packer, top level.
//
// Four code tables of 704 symbols live in one synchronous RAM word per
// symbol (valid, length, reversed code). After reset the block sweeps the
// whole RAM, one entry a cycle, to clear valid marks, with in_ready_o low.
// A define writes its entry in StDefw, after a sweep of its table in
// StClear if start_code is set. An encode reads the RAM, packs in StRead
// and emits each byte in StEmit; raw bits, align and literal pack in
// StIdle and emit in StEmit. The single byte output port, one byte a cycle
// unless out_ready_i stalls it, sets the sustained rate. A finished byte
// waits in the output register while the next request is taken.
module canonical_prefix_code_bit_writer_top
  import cpcbw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            cmd_i,
  input  logic [IdW-1:0]        code_id_i,
  input  logic                  start_code_i,
  input  logic [SymW-1:0]       symbol_i,
  input  logic [LenW-1:0]       code_length_i,
  input  logic [CntW-1:0]       bit_count_i,
  input  logic [MaxRawBits-1:0] bit_value_i,
  input  logic [6:0]            fill_value_i,
  input  logic [7:0]            literal_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            data_byte_o,
  output logic                  is_error_o,
  output logic                  last_of_run_o
);

  state_e            state_q, state_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   tot_q, tot_d;
  logic              err_q, err_d;
  logic [CodeW-1:0]  next_code_q, next_code_d;
  logic [AddrW-1:0]  clr_addr_q, clr_addr_d;
  logic [AddrW-1:0]  clr_end_q, clr_end_d;
  logic              def_pend_q, def_pend_d;
  logic [AddrW-1:0]  def_addr_q, def_addr_d;
  logic [LenW-1:0]   def_len_q, def_len_d;
  logic              sym_ok_q, sym_ok_d;

  logic              out_valid_q;
  logic [7:0]        out_data_q;
  logic              out_err_q;
  logic              out_last_q;

  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  tbl_word_t         mem_wdata, rdata_q;
  tbl_word_t         tbl_mem [TableDepth];

  logic              out_load, load_err, load_last;
  logic [7:0]        load_data;

  logic [CntW-1:0]       raw_n, pk_n;
  logic [MaxRawBits-1:0] pk_v;
  logic [RawMaskW-1:0]   pk_mask;
  logic [AccW-1:0]       pk_acc;
  logic [CntW-1:0]       pk_tot;
  logic [14:0]           fill_wide;
  logic                  sym_in_range;
  logic                  def_ok;

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = out_valid_q;
  assign data_byte_o   = out_data_q;
  assign is_error_o    = out_err_q;
  assign last_of_run_o = out_last_q;

  assign sym_in_range = (32'(symbol_i) < MaxSymbols) && (32'(code_id_i) < NumCodes);
  assign def_ok       = sym_in_range && (32'(code_length_i) <= MaxCodeLength);

  assign raw_n = (32'(bit_count_i) > MaxRawBits) ? CntW'(MaxRawBits) : bit_count_i;

  // shared packer: raw bits from the port, or a code read from the table
  always_comb begin
    if (state_q == StRead) begin
      pk_n = CntW'(rdata_q.len);
      pk_v = MaxRawBits'(rdata_q.code);
    end else begin
      pk_n = raw_n;
      pk_v = bit_value_i;
    end
  end

  assign pk_mask   = (RawMaskW'(1) << pk_n) - RawMaskW'(1);
  assign pk_acc    = acc_q | (AccW'(pk_v & pk_mask[MaxRawBits-1:0]) << tot_q[2:0]);
  assign pk_tot    = tot_q + pk_n;
  assign fill_wide = 15'(acc_q[6:0]) | (15'(fill_value_i) << tot_q[2:0]);

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    tot_d       = tot_q;
    err_d       = err_q;
    next_code_d = next_code_q;
    clr_addr_d  = clr_addr_q;
    clr_end_d   = clr_end_q;
    def_pend_d  = def_pend_q;
    def_addr_d  = def_addr_q;
    def_len_d   = def_len_q;
    sym_ok_d    = sym_ok_q;
    mem_we      = 1'b0;
    mem_waddr   = def_addr_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = tbl_addr(code_id_i, symbol_i);
    out_load    = 1'b0;
    load_data   = '0;
    load_err    = 1'b0;
    load_last   = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          unique case (cmd_i)
            CmdDefine: begin
              if (def_ok) begin
                def_addr_d = tbl_addr(code_id_i, symbol_i);
                def_len_d  = code_length_i;
                if (start_code_i) begin
                  next_code_d = '0;
                  clr_addr_d  = tbl_addr(code_id_i, '0);
                  clr_end_d   = tbl_addr(code_id_i, SymW'(MaxSymbols - 1));
                  def_pend_d  = 1'b1;
                  state_d     = StClear;
                end else begin
                  state_d = StDefw;
                end
              end
            end
            CmdEncode: begin
              mem_re   = sym_in_range;
              sym_ok_d = sym_in_range;
              state_d  = StRead;
            end
            CmdRaw: begin
              acc_d = pk_acc;
              tot_d = pk_tot;
              if (pk_tot >= CntW'(8)) state_d = StEmit;
            end
            CmdAlign: begin
              if (tot_q != '0) begin
                acc_d   = AccW'(fill_wide[7:0]);
                tot_d   = CntW'(8);
                state_d = StEmit;
              end
            end
            CmdLiteral: begin
              // pending bits with zero fill, then the literal byte
              if (tot_q != '0) begin
                acc_d = AccW'({literal_byte_i, acc_q[7:0]});
                tot_d = CntW'(16);
              end else begin
                acc_d = AccW'(literal_byte_i);
                tot_d = CntW'(8);
              end
              state_d = StEmit;
            end
            default: ;
          endcase
        end
      end
      StClear: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + AddrW'(1);
        if (clr_addr_q == clr_end_q) begin
          state_d    = def_pend_q ? StDefw : StIdle;
          def_pend_d = 1'b0;
        end
      end
      StDefw: begin
        mem_we          = 1'b1;
        mem_waddr       = def_addr_q;
        mem_wdata.valid = 1'b1;
        mem_wdata.len   = def_len_q;
        mem_wdata.code  = next_code_q;
        next_code_d     = rev_advance(next_code_q, def_len_q);
        state_d         = StIdle;
      end
      StRead: begin
        if (!(sym_ok_q && rdata_q.valid)) begin
          err_d   = 1'b1;
          state_d = StEmit;
        end else begin
          acc_d   = pk_acc;
          tot_d   = pk_tot;
          state_d = (pk_tot >= CntW'(8)) ? StEmit : StIdle;
        end
      end
      StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (err_q) begin
            load_err  = 1'b1;
            load_last = 1'b1;
            err_d     = 1'b0;
            state_d   = StIdle;
          end else begin
            load_data = acc_q[7:0];
            load_last = (tot_q < CntW'(16));
            acc_d     = acc_q >> 8;
            tot_d     = tot_q - CntW'(8);
            if (load_last) state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // code table RAM
  always_ff @(posedge clk_i) begin
    if (mem_we) tbl_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= tbl_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      acc_q       <= '0;
      tot_q       <= '0;
      err_q       <= 1'b0;
      next_code_q <= '0;
      clr_addr_q  <= '0;
      clr_end_q   <= AddrW'(TableDepth - 1);
      def_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      tot_q       <= tot_d;
      err_q       <= err_d;
      next_code_q <= next_code_d;
      clr_addr_q  <= clr_addr_d;
      clr_end_q   <= clr_end_d;
      def_pend_q  <= def_pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    def_addr_q <= def_addr_d;
    def_len_q  <= def_len_d;
    sym_ok_q   <= sym_ok_d;
    if (out_load) begin
      out_data_q <= load_data;
      out_err_q  <= load_err;
      out_last_q <= load_last;
    end
  end

  // between requests only a partial byte is held
  a_pending_partial : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (tot_q < CntW'(8)))
    else $error("pending bit count reached a full byte while idle");

  a_error_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_data_q == 8'd0 && out_last_q))
    else $error("error result with data or without last mark");

  a_clear_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> (clr_addr_q <= clr_end_q))
    else $error("clearing sweep ran past its end");

  a_no_write_on_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> !mem_we)
    else $error("table read and write in the same cycle");

  a_error_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead && !(sym_ok_q && rdata_q.valid)) |=> (state_q == StEmit && err_q))
    else $error("undefined symbol did not raise an error result");

endmodule

// ===== bench/tb_canonical_prefix_code_bit_writer_top.sv =====
// Self-checking bench for the prefix-code bit writer: random and directed requests vs. a predictor.
`timescale 1ns / 100ps

module tb_canonical_prefix_code_bit_writer_top;
  import cpcbw_pkg::*;

  localparam logic [2:0] CmdSpare5 = 3'd5;
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  localparam int PoolDepth   = 64;
  localparam int PhaseLen    = 40;
  localparam int NumPhases   = 4;
  localparam int RandomReqs  = 385;
  localparam int DrainCycles = 40;

  typedef enum int {PhQuiet, PhSenderGaps, PhSinkStalls, PhBothIdle} idle_phase_e;

  typedef struct packed {
    logic [2:0]            cmd;
    logic [IdW-1:0]        code_id;
    logic                  start_code;
    logic [SymW-1:0]       symbol;
    logic [LenW-1:0]       code_length;
    logic [CntW-1:0]       bit_count;
    logic [MaxRawBits-1:0] bit_value;
    logic [6:0]            fill_value;
    logic [7:0]            literal_byte;
  } bw_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       last;
  } stream_byte_t;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    out_ready_i = 1'b0;
  bw_req_t cur_req     = '0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] data_byte_o;
  logic       is_error_o;
  logic       last_of_run_o;

  canonical_prefix_code_bit_writer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cur_req.cmd),
    .code_id_i     (cur_req.code_id),
    .start_code_i  (cur_req.start_code),
    .symbol_i      (cur_req.symbol),
    .code_length_i (cur_req.code_length),
    .bit_count_i   (cur_req.bit_count),
    .bit_value_i   (cur_req.bit_value),
    .fill_value_i  (cur_req.fill_value),
    .literal_byte_i(cur_req.literal_byte),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .is_error_o    (is_error_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  bw_req_t      req_q [$];
  stream_byte_t want_bytes_q [$];
  stream_byte_t got_want;
  int unsigned  sent_cnt     = 0;
  int unsigned  accepted_cnt = 0;
  int unsigned  total_reqs   = 0;
  int unsigned  stim_cnt     = 0;
  int unsigned  error_cnt    = 0;

  // predictor state
  logic [LenW-1:0]  len_tbl     [TableDepth];
  logic [CodeW-1:0] rcode_tbl   [TableDepth];
  bit               defined_tbl [TableDepth];
  logic [CodeW-1:0] next_rcode = '0;
  logic [6:0]       held_bits  = '0;
  int unsigned      held_cnt   = 0;

  // symbols the stimulus believes are defined, per table
  logic [SymW-1:0] pool_sym [NumCodes][PoolDepth];
  int              pool_n   [NumCodes];

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    error_cnt++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic err);
    stream_byte_t e;
    e.data = b;
    e.err  = err;
    e.last = 1'b0;
    want_bytes_q.insert(want_bytes_q.size(), e);
  endtask

  task automatic pack_lsb_first(input int unsigned nbits, input logic [31:0] bits);
    logic [63:0] mask;
    logic [39:0] acc;
    int unsigned total;
    mask  = (64'd1 << nbits) - 64'd1;
    acc   = 40'(held_bits) | (40'(bits & mask[31:0]) << held_cnt);
    total = held_cnt + nbits;
    while (total >= 8) begin
      push_byte(acc[7:0], 1'b0);
      acc   = acc >> 8;
      total = total - 8;
    end
    held_bits = acc[6:0];
    held_cnt  = total;
  endtask

  task automatic flush_partial(input logic [6:0] fill);
    logic [15:0] w;
    if (held_cnt != 0) begin
      w = 16'(held_bits) | (16'(fill) << held_cnt);
      push_byte(w[7:0], 1'b0);
      held_bits = '0;
      held_cnt  = 0;
    end
  endtask

  task automatic predict_stream_bytes(input bw_req_t r);
    int unsigned  base;
    int unsigned  idx;
    int unsigned  n_before;
    int unsigned  cnt;
    stream_byte_t e;
    n_before = want_bytes_q.size();
    base     = int'(r.code_id) * MaxSymbols;
    idx      = base + int'(r.symbol);
    case (r.cmd)
      CmdDefine: begin
        if (int'(r.code_id) < NumCodes && r.symbol < MaxSymbols &&
            r.code_length <= MaxCodeLength) begin
          if (r.start_code) begin
            for (int i = 0; i < MaxSymbols; i++) defined_tbl[base + i] = 1'b0;
            next_rcode = '0;
          end
          len_tbl[idx]     = r.code_length;
          rcode_tbl[idx]   = next_rcode;
          defined_tbl[idx] = 1'b1;
          // reversed increment: flip from the top of the length down to the first zero
          for (int b = int'(r.code_length) - 1; b >= 0; b--) begin
            next_rcode[b] = ~next_rcode[b];
            if (next_rcode[b]) break;
          end
        end
      end
      CmdEncode: begin
        if (int'(r.code_id) >= NumCodes || r.symbol >= MaxSymbols) push_byte(8'h00, 1'b1);
        else if (!defined_tbl[idx]) push_byte(8'h00, 1'b1);
        else pack_lsb_first(len_tbl[idx], 32'(rcode_tbl[idx]));
      end
      CmdRaw: begin
        cnt = (r.bit_count > MaxRawBits) ? MaxRawBits : r.bit_count;
        pack_lsb_first(cnt, r.bit_value);
      end
      CmdAlign: flush_partial(r.fill_value);
      CmdLiteral: begin
        flush_partial(7'h00);
        push_byte(r.literal_byte, 1'b0);
      end
      default: ;
    endcase
    if (want_bytes_q.size() > n_before) begin
      e      = want_bytes_q[want_bytes_q.size() - 1];
      e.last = 1'b1;
      want_bytes_q[want_bytes_q.size() - 1] = e;
    end
  endtask

  function automatic idle_phase_e idle_phase();
    return idle_phase_e'((sent_cnt / PhaseLen) % NumPhases);
  endfunction

  function automatic bit sender_holds_off();
    bit hold;
    hold = 1'b0;
    case (idle_phase())
      PhSenderGaps: hold = ($urandom_range(0, 99) < 46);
      PhBothIdle:   hold = ($urandom_range(0, 99) < 11);
      default:      hold = 1'b0;
    endcase
    return hold;
  endfunction

  function automatic bit sink_stalls();
    bit hold;
    hold = 1'b0;
    case (idle_phase())
      PhSinkStalls: hold = ($urandom_range(0, 99) < 46);
      PhBothIdle:   hold = ($urandom_range(0, 99) < 11);
      default:      hold = 1'b0;
    endcase
    return hold;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_stream_bytes(cur_req);
        accepted_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (req_q.size() > 0 && !sender_holds_off()) begin
          cur_req    <= req_q.pop_front();
          in_valid_i <= 1'b1;
          sent_cnt++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // byte monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (want_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h err %0b last %0b",
                                    data_byte_o, is_error_o, last_of_run_o));
        end else begin
          got_want = want_bytes_q.pop_front();
          if (data_byte_o !== got_want.data)
            report_mismatch($sformatf("data_byte %02h, want %02h", data_byte_o, got_want.data));
          if (is_error_o !== got_want.err)
            report_mismatch($sformatf("is_error %0b, want %0b", is_error_o, got_want.err));
          if (last_of_run_o !== got_want.last)
            report_mismatch($sformatf("last_of_run %0b, want %0b", last_of_run_o, got_want.last));
        end
      end
      out_ready_i <= !sink_stalls();
    end
  end

  function automatic bw_req_t random_req();
    bw_req_t r;
    r.cmd          = 3'($urandom);
    r.code_id      = IdW'($urandom);
    r.start_code   = 1'($urandom);
    r.symbol       = SymW'($urandom);
    r.code_length  = LenW'($urandom);
    r.bit_count    = CntW'($urandom);
    r.bit_value    = $urandom;
    r.fill_value   = 7'($urandom);
    r.literal_byte = 8'($urandom);
    return r;
  endfunction

  task automatic add_req(input bw_req_t r);
    int id;
    req_q.insert(req_q.size(), r);
    if (r.cmd <= CmdLiteral) stim_cnt++;
    id = int'(r.code_id);
    if (r.cmd == CmdDefine && r.symbol < MaxSymbols) begin
      if (r.start_code) pool_n[id] = 0;
      if (pool_n[id] < PoolDepth) begin
        pool_sym[id][pool_n[id]] = r.symbol;
        pool_n[id]++;
      end
    end
  endtask

  task automatic add_define(input int id, input bit start, input int sym, input int len);
    bw_req_t r;
    r             = random_req();
    r.cmd         = CmdDefine;
    r.code_id     = IdW'(id);
    r.start_code  = start;
    r.symbol      = SymW'(sym);
    r.code_length = LenW'(len);
    add_req(r);
  endtask

  task automatic add_encode(input int id, input int sym);
    bw_req_t r;
    r         = random_req();
    r.cmd     = CmdEncode;
    r.code_id = IdW'(id);
    r.symbol  = SymW'(sym);
    add_req(r);
  endtask

  task automatic add_raw(input int cnt, input logic [31:0] val);
    bw_req_t r;
    r           = random_req();
    r.cmd       = CmdRaw;
    r.bit_count = CntW'(cnt);
    r.bit_value = val;
    add_req(r);
  endtask

  task automatic add_align(input logic [6:0] fill);
    bw_req_t r;
    r            = random_req();
    r.cmd        = CmdAlign;
    r.fill_value = fill;
    add_req(r);
  endtask

  task automatic add_literal(input logic [7:0] lit);
    bw_req_t r;
    r              = random_req();
    r.cmd          = CmdLiteral;
    r.literal_byte = lit;
    add_req(r);
  endtask

  task automatic add_spare(input logic [2:0] cmd);
    bw_req_t r;
    r     = random_req();
    r.cmd = cmd;
    add_req(r);
  endtask

  // table build: lengths never fall; symbols rise within one length, except a wrap at the top length
  task automatic build_table(input int id, input int n);
    int cur_len;
    int sym;
    cur_len = $urandom_range(1, 12);
    sym     = $urandom_range(0, 40);
    for (int k = 0; k < n; k++) begin
      add_define(id, k == 0, sym, cur_len);
      if ($urandom_range(0, 2) == 0 && cur_len < MaxCodeLength) begin
        cur_len = cur_len + $urandom_range(1, 3);
        if (cur_len > MaxCodeLength) cur_len = MaxCodeLength;
        sym = $urandom_range(0, 60);
      end else begin
        sym = sym + $urandom_range(1, 50);
        if (sym >= MaxSymbols) begin
          sym = $urandom_range(0, 30);
          if (cur_len < MaxCodeLength) cur_len++;
        end
      end
    end
  endtask

  initial begin
    int unsigned rand_goal;
    int          pick;
    int          id;
    for (int i = 0; i < NumCodes; i++) pool_n[i] = 0;

    // directed part
    add_encode(0, 0);                // nothing defined yet
    add_align(7'h55);                // nothing pending
    add_literal(8'h00);
    add_define(0, 1'b1, 0, 1);
    add_define(0, 1'b0, 3, 2);
    add_define(0, 1'b0, 4, 3);
    add_define(0, 1'b0, MaxSymbols - 1, 3);
    add_define(0, 1'b1, 900, 4);     // out of range, start dropped too
    add_encode(0, 0);
    add_encode(0, 3);
    add_encode(0, 4);
    add_encode(0, MaxSymbols - 1);
    add_encode(3, 1023);             // symbol out of range
    add_define(0, 1'b0, 3, 4);       // overwrite earlier definition
    add_encode(0, 3);
    add_define(1, 1'b1, 7, 0);       // zero-length code
    add_encode(1, 7);
    add_define(2, 1'b1, 10, MaxCodeLength);
    add_define(2, 1'b0, 11, MaxCodeLength);
    add_encode(2, 11);
    add_define(3, 1'b0, 5, 2);       // code carries over from another table
    add_encode(3, 5);
    add_raw(MaxRawBits, 32'hffff_ffff);
    add_raw(0, 32'h1234_5678);
    add_raw(63, 32'ha5a5_a5a5);      // count saturates
    add_align(7'h7f);
    add_raw(5, 32'h0000_001f);
    add_literal(8'hff);
    add_spare(CmdSpare5);
    add_spare(CmdSpare6);
    add_spare(CmdSpare7);

    // random part
    rand_goal = stim_cnt + RandomReqs;
    for (int i = 0; i < NumCodes; i++) build_table(i, $urandom_range(2, 20));
    while (stim_cnt < rand_goal) begin
      pick = $urandom_range(0, 99);
      id   = $urandom_range(0, NumCodes - 1);
      if (pick < 5) begin
        build_table(id, $urandom_range(2, 20));
      end else if (pick < 50) begin
        if (pool_n[id] > 0) add_encode(id, pool_sym[id][$urandom_range(0, pool_n[id] - 1)]);
        else add_encode(id, $urandom_range(0, MaxSymbols - 1));
      end else if (pick < 54) begin
        add_encode(id, $urandom_range(0, 1023));
      end else if (pick < 72) begin
        if ($urandom_range(0, 6) == 0) add_raw($urandom_range(MaxRawBits + 1, 63), $urandom);
        else add_raw($urandom_range(0, MaxRawBits), $urandom);
      end else if (pick < 80) begin
        add_align(7'($urandom));
      end else if (pick < 88) begin
        add_literal(8'($urandom));
      end else if (pick < 92) begin
        add_define(id, $urandom_range(0, 5) == 0, $urandom_range(0, 1023),
                   $urandom_range(0, MaxCodeLength));
      end else if (pick < 94) begin
        add_spare(3'($urandom_range(CmdSpare5, CmdSpare7)));
      end else begin
        add_raw($urandom_range(1, 7), $urandom);
      end
    end
    total_reqs = req_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (accepted_cnt < total_reqs) @(negedge clk_i);
    while (want_bytes_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (error_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
src/cpcbw_pkg.sv
src/canonical_prefix_code_bit_writer_top.sv
bench/tb_canonical_prefix_code_bit_writer_top.sv
